// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes for the Porter-Duff compositor: blend mode codes, factor kinds
// and the mode-to-factor decode. No dependencies.
package pdc_pkg;

    typedef enum logic [3:0] {
        MODE_CLEAR    = 4'd0,
        MODE_COPY     = 4'd1,
        MODE_DEST     = 4'd2,
        MODE_SRC_OVER = 4'd3,
        MODE_DST_OVER = 4'd4,
        MODE_SRC_IN   = 4'd5,
        MODE_DST_IN   = 4'd6,
        MODE_SRC_OUT  = 4'd7,
        MODE_DST_OUT  = 4'd8,
        MODE_SRC_ATOP = 4'd9,
        MODE_DST_ATOP = 4'd10,
        MODE_XOR      = 4'd11,
        MODE_LIGHTER  = 4'd12
    } mode_t;

    localparam logic [3:0] MODE_RESET = MODE_SRC_OVER;

    typedef enum logic [2:0] {
        FK_ZERO,
        FK_ONE,
        FK_SA,
        FK_DA,
        FK_NSA,
        FK_NDA
    } fk_t;

    typedef struct packed {
        fk_t fs;
        fk_t fd;
    } fpair_t;

    function automatic fpair_t mode_factors(logic [3:0] mode);
        fpair_t f;
        begin
            f.fs = FK_ZERO;
            f.fd = FK_ZERO;
            case (mode)
                MODE_SRC_OVER: begin f.fs = FK_ONE;  f.fd = FK_NSA; end
                MODE_DST_OVER: begin f.fs = FK_NDA;  f.fd = FK_ONE; end
                MODE_SRC_IN:   begin f.fs = FK_DA;   f.fd = FK_ZERO; end
                MODE_DST_IN:   begin f.fs = FK_ZERO; f.fd = FK_SA; end
                MODE_SRC_OUT:  begin f.fs = FK_NDA;  f.fd = FK_ZERO; end
                MODE_DST_OUT:  begin f.fs = FK_ZERO; f.fd = FK_NSA; end
                MODE_SRC_ATOP: begin f.fs = FK_DA;   f.fd = FK_NSA; end
                MODE_DST_ATOP: begin f.fs = FK_NDA;  f.fd = FK_SA; end
                MODE_XOR:      begin f.fs = FK_NDA;  f.fd = FK_NSA; end
                MODE_LIGHTER:  begin f.fs = FK_ONE;  f.fd = FK_ONE; end
                default:       begin f.fs = FK_ZERO; f.fd = FK_ZERO; end
            endcase
            return f;
        end
    endfunction

endpackage

// ===== rtl/porter_duff_pixel_compositor_top.sv =====
`timescale 1ns / 1ps
// Porter-Duff pixel compositor, top level: register, factor pipeline, output.
// Depends on pdc_pkg and pdc_div.
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+---------------------------------------
//  pixel in | pix_valid  | pix_stall  | src_*/dst_* RGBA, span_end
//  result   | res_valid  | res_stall  | out_red/green/blue/alpha, span_end_out
//  config   | cfg_we     | (none)     | cfg_wdata -> blend_mode
//
// One pixel may transfer in every cycle while pix_stall is low; the pipeline is
// four arithmetic stages, CHANNEL_BITS + 2 divider stages and an output register.
// The divider pipeline sets the depth: one quotient bit per stage.
// All stages advance together while the output register is empty or being
// taken; when the result is stalled every stage holds and pix_stall is high.
// Reset clears all valid bits and loads blend_mode with src_over.
module porter_duff_pixel_compositor_top #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [3:0]              cfg_wdata,
    input  logic                    pix_valid,
    output logic                    pix_stall,
    input  logic [CHANNEL_BITS-1:0] src_red,
    input  logic [CHANNEL_BITS-1:0] src_green,
    input  logic [CHANNEL_BITS-1:0] src_blue,
    input  logic [CHANNEL_BITS-1:0] src_alpha,
    input  logic [CHANNEL_BITS-1:0] dst_red,
    input  logic [CHANNEL_BITS-1:0] dst_green,
    input  logic [CHANNEL_BITS-1:0] dst_blue,
    input  logic [CHANNEL_BITS-1:0] dst_alpha,
    input  logic                    span_end,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [CHANNEL_BITS-1:0] out_red,
    output logic [CHANNEL_BITS-1:0] out_green,
    output logic [CHANNEL_BITS-1:0] out_blue,
    output logic [CHANNEL_BITS-1:0] out_alpha,
    output logic                    span_end_out
);

    localparam int N     = CHANNEL_BITS;
    localparam int QUO_W = N + 2;       // colour quotient reaches 2M in lighter
    localparam int DEN_W = 2 * N + 1;
    localparam int NUM_W = 3 * N + 3;
    localparam int DEPTH = 4 + QUO_W;   // stages ahead of the output register
    localparam logic [N-1:0]   MAXV = '1;
    localparam logic [2*N-1:0] FULL = (2*N)'(MAXV) * (2*N)'(MAXV);

    typedef struct packed {
        logic         byp;      // clear, copy, dest or undefined mode
        logic [N-1:0] br;
        logic [N-1:0] bg;
        logic [N-1:0] bb;
        logic [N-1:0] ba;
        logic         a_zero;
        logic         span;
    } side_t;

    logic adv;
    logic [3:0] mode_reg;
    logic [DEPTH-1:0] vld_reg;

    // Advance everything when the output register is free or being taken.
    assign adv       = !res_valid || !res_stall;
    assign pix_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= pdc_pkg::MODE_RESET;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], pix_valid};
    end

    // Stage 1: capture the pixel pair and the mode.
    logic [N-1:0] s1_sc_reg [3];
    logic [N-1:0] s1_dc_reg [3];
    logic [N-1:0] s1_sa_reg, s1_da_reg;
    logic [3:0]   s1_mode_reg;
    logic         s1_span_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sc_reg[0] <= src_red;
            s1_sc_reg[1] <= src_green;
            s1_sc_reg[2] <= src_blue;
            s1_dc_reg[0] <= dst_red;
            s1_dc_reg[1] <= dst_green;
            s1_dc_reg[2] <= dst_blue;
            s1_sa_reg    <= src_alpha;
            s1_da_reg    <= dst_alpha;
            s1_mode_reg  <= mode_reg;
            s1_span_reg  <= span_end;
        end
    end

    // Stage 2: pick the factors, weight each alpha, decide the bypass.
    function automatic logic [N-1:0] fval(pdc_pkg::fk_t k, logic [N-1:0] sa,
                                          logic [N-1:0] da);
        logic [N-1:0] v;
        begin
            case (k)
                pdc_pkg::FK_ONE: v = MAXV;
                pdc_pkg::FK_SA:  v = sa;
                pdc_pkg::FK_DA:  v = da;
                pdc_pkg::FK_NSA: v = MAXV - sa;
                pdc_pkg::FK_NDA: v = MAXV - da;
                default:         v = '0;
            endcase
            return v;
        end
    endfunction

    pdc_pkg::fpair_t fp;
    logic [N-1:0]   fs_val, fd_val;
    side_t          sb2_next;

    assign fp     = pdc_pkg::mode_factors(s1_mode_reg);
    assign fs_val = fval(fp.fs, s1_sa_reg, s1_da_reg);
    assign fd_val = fval(fp.fd, s1_sa_reg, s1_da_reg);

    always_comb
    begin
        sb2_next        = '0;
        sb2_next.span   = s1_span_reg;
        unique case (s1_mode_reg) inside
            pdc_pkg::MODE_CLEAR:
            begin
                sb2_next.byp = 1'b1;
            end
            pdc_pkg::MODE_COPY:
            begin
                sb2_next.byp = 1'b1;
                sb2_next.br  = s1_sc_reg[0];
                sb2_next.bg  = s1_sc_reg[1];
                sb2_next.bb  = s1_sc_reg[2];
                sb2_next.ba  = s1_sa_reg;
            end
            [pdc_pkg::MODE_SRC_OVER:pdc_pkg::MODE_LIGHTER]:
            begin
                sb2_next.byp = 1'b0;
            end
            default:
            begin
                // dest and undefined codes pass the destination through
                sb2_next.byp = 1'b1;
                sb2_next.br  = s1_dc_reg[0];
                sb2_next.bg  = s1_dc_reg[1];
                sb2_next.bb  = s1_dc_reg[2];
                sb2_next.ba  = s1_da_reg;
            end
        endcase
    end

    logic [2*N-1:0] s2_ws_reg, s2_wd_reg;
    logic [N-1:0]   s2_sc_reg [3];
    logic [N-1:0]   s2_dc_reg [3];
    side_t          s2_sb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ws_reg <= (2*N)'(s1_sa_reg) * (2*N)'(fs_val);
            s2_wd_reg <= (2*N)'(s1_da_reg) * (2*N)'(fd_val);
            s2_sc_reg <= s1_sc_reg;
            s2_dc_reg <= s1_dc_reg;
            s2_sb_reg <= sb2_next;
        end
    end

    // Stage 3: output alpha (clamped at full) and the colour products.
    logic [2*N:0]   a_sum;
    logic [2*N-1:0] a_clamp;

    assign a_sum   = (2*N+1)'(s2_ws_reg) + (2*N+1)'(s2_wd_reg);
    assign a_clamp = (a_sum > (2*N+1)'(FULL)) ? FULL : a_sum[2*N-1:0];

    logic [2*N-1:0] s3_a_reg;
    logic [3*N-1:0] s3_ps_reg [3];
    logic [3*N-1:0] s3_pd_reg [3];
    side_t          s3_sb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_ps_reg[i] <= (3*N)'(s2_sc_reg[i]) * (3*N)'(s2_ws_reg);
                s3_pd_reg[i] <= (3*N)'(s2_dc_reg[i]) * (3*N)'(s2_wd_reg);
            end
            s3_a_reg  <= a_clamp;
            s3_sb_reg <= s2_sb_reg;
        end
    end

    // Stage 4: build rounded numerators; colour = (2P + A) / 2A.
    // Alpha = (A + M/2) / M by shift and add: with y below 2^(2N),
    // y / (2^N - 1) is (y + (y >> N) + 1) >> N. It rides the sideband.
    logic [NUM_W-1:0] s4_num_reg [3];
    logic [DEN_W-1:0] s4_den_reg [3];
    side_t            s4_sb_reg;
    side_t            sb4_next;
    logic [2*N-1:0]   a_y;
    logic [2*N:0]     a_t;

    assign a_y = s3_a_reg + (2*N)'(MAXV >> 1);
    assign a_t = (2*N+1)'(a_y) + (2*N+1)'(a_y >> N) + (2*N+1)'(1);

    always_comb
    begin
        sb4_next        = s3_sb_reg;
        sb4_next.a_zero = (s3_a_reg == '0);
        if (!s3_sb_reg.byp)
            sb4_next.ba = a_t[2*N-1:N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_num_reg[i] <= ((NUM_W'(s3_ps_reg[i]) + NUM_W'(s3_pd_reg[i])) << 1)
                                 + NUM_W'(s3_a_reg);
                s4_den_reg[i] <= {s3_a_reg, 1'b0};
            end
            s4_sb_reg <= sb4_next;
        end
    end

    // Divider lanes: one per colour.
    logic [QUO_W-1:0] quo [3];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        pdc_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .QUO_W (QUO_W)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (s4_num_reg[l]),
            .den (s4_den_reg[l]),
            .quo (quo[l])
        );
    end

    // Sideband rides along the divider stages.
    side_t sd_reg [QUO_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= s4_sb_reg;
            for (int i = 1; i < QUO_W; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // Output stage: saturate, zero colour on zero alpha, apply bypass.
    function automatic logic [N-1:0] sat(logic [QUO_W-1:0] q, logic z);
        logic [N-1:0] v;
        begin
            if (z)
                v = '0;
            else if (q > QUO_W'(MAXV))
                v = MAXV;
            else
                v = q[N-1:0];
            return v;
        end
    endfunction

    side_t        sb_last;
    logic [N-1:0] r_next, g_next, b_next, a_next;

    assign sb_last = sd_reg[QUO_W-1];

    always_comb
    begin
        if (sb_last.byp)
        begin
            r_next = sb_last.br;
            g_next = sb_last.bg;
            b_next = sb_last.bb;
            a_next = sb_last.ba;
        end
        else
        begin
            r_next = sat(quo[0], sb_last.a_zero);
            g_next = sat(quo[1], sb_last.a_zero);
            b_next = sat(quo[2], sb_last.a_zero);
            a_next = sb_last.ba;
        end
    end

    logic         res_valid_reg;
    logic [N-1:0] out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic         span_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg    <= r_next;
            out_g_reg    <= g_next;
            out_b_reg    <= b_next;
            out_a_reg    <= a_next;
            span_out_reg <= sb_last.span;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_red      = out_r_reg;
    assign out_green    = out_g_reg;
    assign out_blue     = out_b_reg;
    assign out_alpha    = out_a_reg;
    assign span_end_out = span_out_reg;

endmodule

// ===== rtl/pdc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by the compositor top level.
module pdc_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 17,
    parameter int QUO_W = 10
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int BIT = QUO_W - 1 - k;
        logic [CMP_W-1:0] rem_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QUO_W-1:0] q_reg;
        logic [CMP_W-1:0] rem_in;
        logic [CMP_W-1:0] sub;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = CMP_W'(num);
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = g_step[k-1].rem_reg;
            assign den_in = g_step[k-1].den_reg;
            assign q_in   = g_step[k-1].q_reg;
        end

        assign sub = CMP_W'(den_in) << BIT;
        assign ge  = (rem_in >= sub);

        // Subtract the shifted divisor when it fits, set this quotient bit.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= ge ? (rem_in - sub) : rem_in;
                den_reg <= den_in;
                q_reg   <= q_in | (QUO_W'(ge) << BIT);
            end
        end
    end

    assign quo = g_step[QUO_W-1].q_reg;

endmodule

// ===== rtl/pdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the Porter-Duff compositor, bound to the top level.
// Depends only on the top level's ports.
module pdc_checker #(
    parameter int CHANNEL_BITS = 8
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    pix_stall,
    input logic                    res_valid,
    input logic                    res_stall,
    input logic [CHANNEL_BITS-1:0] out_red,
    input logic [CHANNEL_BITS-1:0] out_alpha
);

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(out_red) && $stable(out_alpha))
        else $error("stalled result changed");

    // Input backpressure only comes from a stalled, full output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled without output backpressure");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !pix_stall)
        else $error("input stalled with empty output");

endmodule

bind porter_duff_pixel_compositor_top pdc_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_pdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_red   (out_red),
    .out_alpha (out_alpha)
);
